/* rtl/esdf_pkg.sv */
`timescale 1ns / 1ps
// Shared constants, codes and types for the distance-field sampler.
// No dependencies; the map, interp and sampler files refer to it by scoped names.
package esdf_pkg;

  localparam int MAX_W   = 256;
  localparam int MAX_H   = 256;
  localparam int FRAC_W  = 16;
  localparam int COL_W   = $clog2(MAX_W);
  localparam int ROW_W   = $clog2(MAX_H);
  localparam int ADDR_W  = COL_W + ROW_W;
  localparam int DEPTH   = MAX_W * MAX_H;
  localparam int VAL_W   = 32;
  localparam int CELL_W  = 3 * VAL_W;
  localparam int DIM_W   = 9;

  typedef enum logic [2:0] {
    CFG_ORIGIN_X = 3'd0,
    CFG_ORIGIN_Y = 3'd1,
    CFG_INV_RES  = 3'd2,
    CFG_WIDTH    = 3'd3,
    CFG_HEIGHT   = 3'd4,
    CFG_MAX_DIST = 3'd5,
    CFG_LAYERS   = 3'd6
  } cfg_idx_e;

  typedef enum logic {
    OP_LOAD  = 1'b0,
    OP_QUERY = 1'b1
  } opcode_e;

  typedef struct packed {
    logic [31:0]      origin_x;
    logic [31:0]      origin_y;
    logic [31:0]      inv_res;
    logic [DIM_W-1:0] width;
    logic [DIM_W-1:0] height;
    logic [30:0]      max_dist;
    logic [1:0]       layers;
  } cfg_t;

  // Mapped word leaving the coordinate stages
  typedef struct packed {
    logic              valid;
    opcode_e           op;
    logic              in_grid;
    logic [ADDR_W-1:0] addr;
    logic [FRAC_W-1:0] fx;
    logic [FRAC_W-1:0] fy;
  } map_t;

endpackage

/* rtl/esdf_ram.sv */
`timescale 1ns / 1ps
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module esdf_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read, held while not enabled
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

/* rtl/esdf_map.sv */
`timescale 1ns / 1ps
// Coordinate stages: origin subtract, scale by inverse resolution, split into
// cell index and fraction, range test and base address. Uses esdf_pkg.
module esdf_map (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      en_i,
  input  logic                      valid_i,
  input  esdf_pkg::opcode_e         op_i,
  input  logic [esdf_pkg::ADDR_W-1:0] cell_address_i,
  input  logic [31:0]               query_x_i,
  input  logic [31:0]               query_y_i,
  input  esdf_pkg::cfg_t            cfg_i,
  output logic [esdf_pkg::DIM_W-1:0] w_eff_o,
  output esdf_pkg::map_t            map_o
);

  // Stage 1 registers
  logic                        v1_q;
  esdf_pkg::opcode_e           op1_q;
  logic [esdf_pkg::ADDR_W-1:0] addr1_q;
  logic [32:0]                 dx1_q, dy1_q;
  // Stage 2 registers
  logic                        v2_q;
  esdf_pkg::opcode_e           op2_q;
  logic [esdf_pkg::ADDR_W-1:0] addr2_q;
  logic [63:0]                 px2_q, py2_q;
  logic                        bad2_q;
  // Stage 3 registers
  logic                        v3_q;
  esdf_pkg::opcode_e           op3_q;
  logic                        in3_q;
  logic [esdf_pkg::ADDR_W-1:0] addr3_q;
  logic [esdf_pkg::FRAC_W-1:0] fx3_q, fy3_q;

  logic [32:0]                 dx1_d, dy1_d;
  logic [31:0]                 magx, magy;
  logic                        bad2_d;
  logic [31:0]                 ix, iy;
  logic [esdf_pkg::DIM_W-1:0]  w_eff, h_eff;
  logic                        in_grid_d;
  logic [esdf_pkg::ADDR_W:0]   base;

  // Subtract the grid origin
  assign dx1_d = {query_x_i[31], query_x_i} - {cfg_i.origin_x[31], cfg_i.origin_x};
  assign dy1_d = {query_y_i[31], query_y_i} - {cfg_i.origin_y[31], cfg_i.origin_y};

  // Scale; a negative offset counts as outside unless the scale is zero
  assign magx   = dx1_q[32] ? 32'd0 : dx1_q[31:0];
  assign magy   = dy1_q[32] ? 32'd0 : dy1_q[31:0];
  assign bad2_d = (dx1_q[32] || dy1_q[32]) && (cfg_i.inv_res != 32'd0);

  // Clamp the grid size, test the 2x2 neighbourhood, form the base address
  assign w_eff = (cfg_i.width > esdf_pkg::DIM_W'(esdf_pkg::MAX_W))
               ? esdf_pkg::DIM_W'(esdf_pkg::MAX_W) : cfg_i.width;
  assign h_eff = (cfg_i.height > esdf_pkg::DIM_W'(esdf_pkg::MAX_H))
               ? esdf_pkg::DIM_W'(esdf_pkg::MAX_H) : cfg_i.height;
  assign ix = px2_q[63:32];
  assign iy = py2_q[63:32];
  assign in_grid_d = !bad2_q
                  && (({1'b0, ix} + 33'd1) < {24'd0, w_eff})
                  && (({1'b0, iy} + 33'd1) < {24'd0, h_eff});
  assign base = (esdf_pkg::ADDR_W + 1)'(iy[esdf_pkg::ROW_W-1:0])
              * (esdf_pkg::ADDR_W + 1)'(w_eff)
              + (esdf_pkg::ADDR_W + 1)'(ix[esdf_pkg::COL_W-1:0]);

  // Valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else if (en_i) begin
      v1_q <= valid_i;
      v2_q <= v1_q;
      v3_q <= v2_q;
    end
  end

  // Payload
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      op1_q   <= op_i;
      addr1_q <= cell_address_i;
      dx1_q   <= dx1_d;
      dy1_q   <= dy1_d;

      op2_q   <= op1_q;
      addr2_q <= addr1_q;
      px2_q   <= magx * cfg_i.inv_res;
      py2_q   <= magy * cfg_i.inv_res;
      bad2_q  <= bad2_d;

      op3_q   <= op2_q;
      in3_q   <= in_grid_d;
      addr3_q <= (op2_q == esdf_pkg::OP_QUERY) ? base[esdf_pkg::ADDR_W-1:0] : addr2_q;
      fx3_q   <= px2_q[31 -: esdf_pkg::FRAC_W];
      fy3_q   <= py2_q[31 -: esdf_pkg::FRAC_W];
    end
  end

  assign map_o   = '{valid: v3_q, op: op3_q, in_grid: in3_q, addr: addr3_q,
                     fx: fx3_q, fy: fy3_q};
  assign w_eff_o = w_eff;

endmodule

/* rtl/esdf_interp.sv */
`timescale 1ns / 1ps
// Bilinear blend of one layer: registered x pass over both rows, then the
// combinational y pass; both passes round half up. Uses esdf_pkg.
module esdf_interp (
  input  logic                       clk_i,
  input  logic                       en_i,
  input  logic [31:0]                c00_i,
  input  logic [31:0]                c01_i,
  input  logic [31:0]                c10_i,
  input  logic [31:0]                c11_i,
  input  logic [esdf_pkg::FRAC_W-1:0] fx_i,
  input  logic [esdf_pkg::FRAC_W-1:0] fy_i,
  output logic [31:0]                result_o
);

  localparam int WT_W  = esdf_pkg::FRAC_W + 1;
  localparam int SUM_W = 32 + WT_W + 1;

  logic [31:0]                 r0_q, r1_q;
  logic [esdf_pkg::FRAC_W-1:0] fy_q;

  // Weighted pair, rounded half up back to the value grid
  function automatic logic [31:0] blend(input logic [31:0] a, input logic [31:0] b,
                                         input logic [esdf_pkg::FRAC_W-1:0] f);
    logic signed [SUM_W-1:0] wb, wa, ea, eb;
    logic signed [SUM_W-1:0] s;
    begin
      wb = $signed(SUM_W'(f));
      wa = $signed(SUM_W'(1 << esdf_pkg::FRAC_W)) - wb;
      ea = SUM_W'($signed(a));
      eb = SUM_W'($signed(b));
      s  = ea * wa + eb * wb + $signed(SUM_W'(1 << (esdf_pkg::FRAC_W - 1)));
      blend = s[esdf_pkg::FRAC_W +: 32];
    end
  endfunction

  // Pass along x in both rows
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      r0_q <= blend(c00_i, c01_i, fx_i);
      r1_q <= blend(c10_i, c11_i, fx_i);
      fy_q <= fy_i;
    end
  end

  // Pass along y
  assign result_o = blend(r0_q, r1_q, fy_q);

endmodule

/* rtl/esdf_bilinear_sampler.sv */
`timescale 1ns / 1ps
// A query word passes the coordinate stages, store read, x pass and output
// register; a load word writes the cell stores after the coordinate stages, with
// no output. One word per cycle, but the whole pipeline holds while the output
// word waits; four replicated cell stores serve the four corners in one read.
// Reset clears valid bits and configuration; data registers and cell stores stay.
module esdf_bilinear_sampler (
  input  logic         clk_i,
  input  logic         rst_ni,
  // configuration
  input  logic         cfg_we_i,
  input  logic [2:0]   cfg_idx_i,
  input  logic [31:0]  cfg_wdata_i,
  // input stream
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // cell_address[15:0], load_distance[47:16], load_grad_x[79:48],
  // load_grad_y[111:80], query_x[143:112], query_y[175:144]
  input  logic [175:0] s_axis_tdata,
  input  logic         s_axis_tuser,   // opcode
  // output stream
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // distance[31:0], grad_x[63:32], grad_y[95:64]
  output logic [95:0]  m_axis_tdata,
  output logic         m_axis_tuser    // in_range
);

  esdf_pkg::cfg_t  cfg_q;
  esdf_pkg::map_t  map3;
  logic            en;
  logic [esdf_pkg::DIM_W-1:0] w_eff;

  logic [esdf_pkg::CELL_W-1:0] cell1_q, cell2_q, cell3_q;
  logic [esdf_pkg::CELL_W-1:0] corner [4];
  logic [esdf_pkg::ADDR_W-1:0] raddr  [4];
  logic [esdf_pkg::ADDR_W-1:0] w_addr;
  logic                        we;

  logic                        v4_q, q4_q, in4_q;
  logic [esdf_pkg::FRAC_W-1:0] fx4_q, fy4_q;
  logic                        v5_q, q5_q, in5_q;
  logic [31:0]                 res [3];

  logic        out_valid_q, in_range_q;
  logic [95:0] out_data_q;
  logic        use_dist, use_grad;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.origin_x <= 32'd0;
      cfg_q.origin_y <= 32'd0;
      cfg_q.inv_res  <= 32'd655360;
      cfg_q.width    <= esdf_pkg::DIM_W'(256);
      cfg_q.height   <= esdf_pkg::DIM_W'(256);
      cfg_q.max_dist <= 31'd655360;
      cfg_q.layers   <= 2'd0;
    end else if (cfg_we_i) begin
      unique case (esdf_pkg::cfg_idx_e'(cfg_idx_i))
        esdf_pkg::CFG_ORIGIN_X: cfg_q.origin_x <= cfg_wdata_i;
        esdf_pkg::CFG_ORIGIN_Y: cfg_q.origin_y <= cfg_wdata_i;
        esdf_pkg::CFG_INV_RES:  cfg_q.inv_res  <= cfg_wdata_i;
        esdf_pkg::CFG_WIDTH:    cfg_q.width    <= cfg_wdata_i[esdf_pkg::DIM_W-1:0];
        esdf_pkg::CFG_HEIGHT:   cfg_q.height   <= cfg_wdata_i[esdf_pkg::DIM_W-1:0];
        esdf_pkg::CFG_MAX_DIST: cfg_q.max_dist <= cfg_wdata_i[30:0];
        esdf_pkg::CFG_LAYERS:   cfg_q.layers   <= cfg_wdata_i[1:0];
        default: ;
      endcase
    end
  end

  // Advance the pipeline whenever the output register is free or drains
  assign en            = !out_valid_q || m_axis_tready;
  assign s_axis_tready = en;

  esdf_map u_map (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .en_i           (en),
    .valid_i        (s_axis_tvalid),
    .op_i           (esdf_pkg::opcode_e'(s_axis_tuser)),
    .cell_address_i (s_axis_tdata[15:0]),
    .query_x_i      (s_axis_tdata[143:112]),
    .query_y_i      (s_axis_tdata[175:144]),
    .cfg_i          (cfg_q),
    .w_eff_o        (w_eff),
    .map_o          (map3)
  );

  // Carry load values alongside the coordinate stages
  always_ff @(posedge clk_i) begin
    if (en) begin
      cell1_q <= s_axis_tdata[111:16];
      cell2_q <= cell1_q;
      cell3_q <= cell2_q;
    end
  end

  // Corner addresses and store write
  assign w_addr   = esdf_pkg::ADDR_W'(map3.addr) ;
  assign raddr[0] = map3.addr;
  assign raddr[1] = map3.addr + esdf_pkg::ADDR_W'(1);
  assign raddr[2] = map3.addr + esdf_pkg::ADDR_W'(w_eff);
  assign raddr[3] = map3.addr + esdf_pkg::ADDR_W'(w_eff) + esdf_pkg::ADDR_W'(1);
  assign we       = en && map3.valid && (map3.op == esdf_pkg::OP_LOAD);

  for (genvar k = 0; k < 4; k++) begin : g_store
    esdf_ram #(
      .WIDTH (esdf_pkg::CELL_W),
      .DEPTH (esdf_pkg::DEPTH)
    ) u_ram (
      .clk_i   (clk_i),
      .we_i    (we),
      .waddr_i (w_addr),
      .wdata_i (cell3_q),
      .re_i    (en),
      .raddr_i (raddr[k]),
      .rdata_o (corner[k])
    );
  end

  // Stage control beside the store read and the x pass
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v4_q <= 1'b0;
      v5_q <= 1'b0;
    end else if (en) begin
      v4_q <= map3.valid;
      v5_q <= v4_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      q4_q  <= (map3.op == esdf_pkg::OP_QUERY);
      in4_q <= map3.in_grid;
      fx4_q <= map3.fx;
      fy4_q <= map3.fy;
      q5_q  <= q4_q;
      in5_q <= in4_q;
    end
  end

  for (genvar l = 0; l < 3; l++) begin : g_layer
    esdf_interp u_interp (
      .clk_i    (clk_i),
      .en_i     (en),
      .c00_i    (corner[0][l*esdf_pkg::VAL_W +: esdf_pkg::VAL_W]),
      .c01_i    (corner[1][l*esdf_pkg::VAL_W +: esdf_pkg::VAL_W]),
      .c10_i    (corner[2][l*esdf_pkg::VAL_W +: esdf_pkg::VAL_W]),
      .c11_i    (corner[3][l*esdf_pkg::VAL_W +: esdf_pkg::VAL_W]),
      .fx_i     (fx4_q),
      .fy_i     (fy4_q),
      .result_o (res[l])
    );
  end

  // Pick interpolated values or the fallbacks
  assign use_dist = in5_q && cfg_q.layers[0];
  assign use_grad = in5_q && cfg_q.layers[1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (en) begin
      out_valid_q <= v5_q && q5_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      out_data_q[31:0]  <= use_dist ? res[0] : {1'b0, cfg_q.max_dist};
      out_data_q[63:32] <= use_grad ? res[1] : 32'd0;
      out_data_q[95:64] <= use_grad ? res[2] : 32'd0;
      in_range_q        <= in5_q;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;
  assign m_axis_tuser  = in_range_q;

endmodule
